@@ rtl/lshs_pkg.sv @@
// shared types, constants and widths of the link stop-handshake supervisor
package lshs_pkg;

    // sequence counter width, 8 to 32
    localparam int SEQ_BITS = 16;
    // width used to compare a received ack sequence with the pending one
    localparam int SEQ_CMP_BITS = (SEQ_BITS > 16) ? SEQ_BITS : 16;

    localparam int REQ_TYPE_BITS = 3;
    localparam int CFG_INDEX_BITS = 3;

    // request types
    localparam logic [REQ_TYPE_BITS-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_ACK    = 3'd1;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_STATUS = 3'd2;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_FAULT  = 3'd3;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_STOP   = 3'd4;

    // frame kinds
    localparam logic [1:0] FRAME_STOP       = 2'd0;
    localparam logic [1:0] FRAME_HEARTBEAT  = 2'd1;
    localparam logic [1:0] FRAME_STATUS_REQ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_RETRY     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEARTBEAT      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STATUS_REQUEST = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESP_TIMEOUT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STATUS_FRESH   = 3'd4;

    // configuration reset values
    localparam logic [15:0] STOP_RETRY_RESET     = 16'd250;
    localparam logic [15:0] HEARTBEAT_RESET      = 16'd500;
    localparam logic [15:0] STATUS_REQUEST_RESET = 16'd1000;
    localparam logic [15:0] RESP_TIMEOUT_RESET   = 16'd1200;
    localparam logic [15:0] STATUS_FRESH_RESET   = 16'd500;

    typedef logic [SEQ_BITS-1:0] t_seq;

    typedef struct packed {
        logic [15:0] stop_retry_ms;
        logic [15:0] heartbeat_ms;
        logic [15:0] status_request_ms;
        logic [15:0] response_timeout_ms;
        logic [15:0] status_fresh_ms;
    } t_cfg;

    typedef struct packed {
        t_seq        control_seq;
        t_seq        aux_seq;
        t_seq        pending_stop_seq;
        logic [31:0] next_stop_time;
        logic [31:0] next_heartbeat_time;
        logic [31:0] next_status_req_time;
        logic [31:0] last_response_time;
        logic [31:0] stop_ack_time;
        logic [31:0] status_time;
        logic [31:0] loss_count;
        logic [31:0] retry_count;
        logic        stop_acked;
        logic        link_up;
        logic        status_valid;
        logic        status_zero_drive;
        logic        first_stop;
    } t_state;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [15:0] frame_seq;
        logic        online;
        logic [31:0] link_losses;
        logic [31:0] stop_count;
        logic        last;
    } t_result;

endpackage

@@ rtl/lshs_ifs.sv @@
// channel interfaces of the link stop-handshake supervisor

interface lshs_req_if;
    import lshs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_BITS-1:0] req_type;
    logic [31:0]              now_ms;
    logic [15:0]              ack_seq;
    logic                     ack_is_stop;
    logic                     ack_ok;
    logic signed [15:0]       left_pwm;
    logic signed [15:0]       right_pwm;

    modport source (output valid, req_type, now_ms, ack_seq, ack_is_stop, ack_ok,
                    left_pwm, right_pwm, input ready);
    modport sink (input valid, req_type, now_ms, ack_seq, ack_is_stop, ack_ok,
                  left_pwm, right_pwm, output ready);
endinterface

interface lshs_frm_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [15:0] frame_seq;
    logic        online;
    logic [31:0] link_losses;
    logic [31:0] stop_count;
    logic        last;

    modport source (output valid, frame_kind, frame_seq, online, link_losses,
                    stop_count, last, input ready);
    modport sink (input valid, frame_kind, frame_seq, online, link_losses,
                  stop_count, last, output ready);
endinterface

interface lshs_cfg_if;
    import lshs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [15:0]               data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/link_stop_handshake_supervisor.sv @@
// link stop-handshake supervisor: event processing, deadlines and frame queue
//
// usage
//   i_req carries one event word per handshake: tick, ack, status report,
//   receive fault or stop request, each stamped with a millisecond time.
//   o_frm carries the frames a tick calls for (STOP retry while offline,
//   heartbeat and status request while online), up to two per tick, with
//   last set on the final frame of that tick.  acks, status reports, faults
//   and stop requests only update state and give no frame.
//   i_cfg writes the five interval registers; it is always ready and must
//   only be used while the block is idle.
// timing
//   an event is taken when valid meets ready; its frames go into the frame
//   queue and leave on o_frm, one frame word per cycle while o_frm is ready.
//   i_req takes one event per cycle while the four-entry frame queue has room
//   for two more frames, bounded by one frame per cycle on o_frm.
// reset and stall
//   i_rst_n low clears the handshake state, counters, queue and loads the
//   interval defaults; the first offline tick after reset always sends STOP.
//   when the receiver stalls, frames wait in the queue and i_req drops ready
//   once fewer than two queue slots are free.
module link_stop_handshake_supervisor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lshs_req_if.sink   i_req,
    lshs_frm_if.source o_frm,
    lshs_cfg_if.sink   i_cfg
);
    import lshs_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // handshake state after reset: control and pending STOP sequences at one, first STOP pending
    localparam t_state STATE_RESET = '{
        control_seq:      SEQ_BITS'(1),
        pending_stop_seq: SEQ_BITS'(1),
        first_stop:       1'b1,
        default:          '0
    };

    // wrap-safe "time now is at or past when"
    function automatic logic f_reached(logic [31:0] now, logic [31:0] when);
        logic [31:0] diff;
        diff = now - when;
        return ~diff[31];
    endfunction

    // drop the link and start a new STOP handshake
    function automatic t_state f_restart(t_state s, logic [31:0] now, logic count_loss);
        t_state r;
        r = s;
        r.link_up          = 1'b0;
        r.stop_acked       = 1'b0;
        r.stop_ack_time    = '0;
        r.control_seq      = s.control_seq + SEQ_BITS'(1);
        r.pending_stop_seq = s.control_seq + SEQ_BITS'(1);
        r.next_stop_time   = now;
        r.status_valid     = 1'b0;
        if (count_loss) begin
            r.loss_count = s.loss_count + 32'd1;
        end
        return r;
    endfunction

    t_cfg    r_cfg;
    t_state  r_s, n_s;

    // frame queue
    t_result r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    t_result     n_res [2];
    logic [1:0]  n_push;
    logic [1:0]  n_kind [2];
    t_seq        n_seq [2];
    logic        w_req_fire, w_frm_fire;
    logic [31:0] w_now;
    logic [31:0] w_status_age, w_silence;

    assign i_req.ready = (r_count <= CNT_BITS'(QUEUE_DEPTH - 2));
    assign i_cfg.ready = 1'b1;
    assign w_req_fire  = i_req.valid & i_req.ready;
    assign w_frm_fire  = o_frm.valid & o_frm.ready;
    assign w_now       = i_req.now_ms;

    assign o_frm.valid       = (r_count != '0);
    assign o_frm.frame_kind  = r_queue[r_rd_ptr].frame_kind;
    assign o_frm.frame_seq   = r_queue[r_rd_ptr].frame_seq;
    assign o_frm.online      = r_queue[r_rd_ptr].online;
    assign o_frm.link_losses = r_queue[r_rd_ptr].link_losses;
    assign o_frm.stop_count  = r_queue[r_rd_ptr].stop_count;
    assign o_frm.last        = r_queue[r_rd_ptr].last;

    assign w_status_age = w_now - r_s.status_time;

    // event processing: next state and the frames of a tick
    always_comb begin
        n_s       = r_s;
        n_push    = 2'd0;
        n_kind[0] = FRAME_STOP;
        n_kind[1] = FRAME_STOP;
        n_seq[0]  = '0;
        n_seq[1]  = '0;
        w_silence = '0;
        if (w_req_fire) begin
            case (i_req.req_type)
                REQ_TICK: begin
                    // judge the latest status report
                    if (r_s.status_valid && (w_status_age <= {16'd0, r_cfg.status_fresh_ms})) begin
                        n_s.last_response_time = r_s.status_time;
                        if (r_s.stop_acked && f_reached(r_s.status_time, r_s.stop_ack_time)
                                && r_s.status_zero_drive) begin
                            n_s.link_up = 1'b1;
                        end else if (r_s.link_up) begin
                            n_s = f_restart(n_s, w_now, 1'b1);
                        end
                    end else if (r_s.link_up) begin
                        n_s = f_restart(n_s, w_now, 1'b1);
                    end
                    // silence after the STOP ack
                    w_silence = w_now - n_s.last_response_time;
                    if (n_s.stop_acked && (w_silence > {16'd0, r_cfg.response_timeout_ms})) begin
                        n_s = f_restart(n_s, w_now, 1'b1);
                    end
                    if (!n_s.link_up) begin
                        if (n_s.first_stop || f_reached(w_now, n_s.next_stop_time)) begin
                            n_kind[0]          = FRAME_STOP;
                            n_seq[0]           = n_s.pending_stop_seq;
                            n_push             = 2'd1;
                            n_s.retry_count    = n_s.retry_count + 32'd1;
                            n_s.next_stop_time = w_now + {16'd0, r_cfg.stop_retry_ms};
                            n_s.first_stop     = 1'b0;
                        end
                    end else begin
                        if (f_reached(w_now, n_s.next_heartbeat_time)) begin
                            n_kind[0]               = FRAME_HEARTBEAT;
                            n_seq[0]                = n_s.aux_seq;
                            n_push                  = 2'd1;
                            n_s.aux_seq             = n_s.aux_seq + SEQ_BITS'(1);
                            n_s.next_heartbeat_time = w_now + {16'd0, r_cfg.heartbeat_ms};
                        end
                        if (f_reached(w_now, n_s.next_status_req_time)) begin
                            n_kind[n_push[0]]        = FRAME_STATUS_REQ;
                            n_seq[n_push[0]]         = n_s.aux_seq;
                            n_push                   = n_push + 2'd1;
                            n_s.aux_seq              = n_s.aux_seq + SEQ_BITS'(1);
                            n_s.next_status_req_time = w_now + {16'd0, r_cfg.status_request_ms};
                        end
                    end
                end
                REQ_ACK: begin
                    n_s.last_response_time = w_now;
                    if (!r_s.stop_acked
                            && (SEQ_CMP_BITS'(i_req.ack_seq) == SEQ_CMP_BITS'(r_s.pending_stop_seq))
                            && i_req.ack_is_stop && i_req.ack_ok) begin
                        n_s.stop_acked           = 1'b1;
                        n_s.stop_ack_time        = w_now;
                        n_s.next_heartbeat_time  = w_now;
                        n_s.next_status_req_time = w_now;
                    end
                end
                REQ_STATUS: begin
                    n_s.status_valid      = 1'b1;
                    n_s.status_time       = w_now;
                    n_s.status_zero_drive = (i_req.left_pwm == 16'sd0)
                                            && (i_req.right_pwm == 16'sd0);
                end
                REQ_FAULT: begin
                    n_s = f_restart(r_s, w_now, 1'b1);
                end
                REQ_STOP: begin
                    n_s = f_restart(r_s, w_now, 1'b0);
                end
                default: begin
                    // unused request codes are dropped
                end
            endcase
        end
        // every frame of a tick reports the state after the whole tick
        for (int k = 0; k < 2; k++) begin
            n_res[k].frame_kind  = n_kind[k];
            n_res[k].frame_seq   = 16'(n_seq[k]);
            n_res[k].online      = n_s.link_up;
            n_res[k].link_losses = n_s.loss_count;
            n_res[k].stop_count  = n_s.retry_count;
            n_res[k].last        = (n_push == 2'(k + 1));
        end
    end

    // state, configuration and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_retry_ms       <= STOP_RETRY_RESET;
            r_cfg.heartbeat_ms        <= HEARTBEAT_RESET;
            r_cfg.status_request_ms   <= STATUS_REQUEST_RESET;
            r_cfg.response_timeout_ms <= RESP_TIMEOUT_RESET;
            r_cfg.status_fresh_ms     <= STATUS_FRESH_RESET;
            r_s                       <= STATE_RESET;
            r_wr_ptr                  <= '0;
            r_rd_ptr                  <= '0;
            r_count                   <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_STOP_RETRY:     r_cfg.stop_retry_ms       <= i_cfg.data;
                    CFG_HEARTBEAT:      r_cfg.heartbeat_ms        <= i_cfg.data;
                    CFG_STATUS_REQUEST: r_cfg.status_request_ms   <= i_cfg.data;
                    CFG_RESP_TIMEOUT:   r_cfg.response_timeout_ms <= i_cfg.data;
                    CFG_STATUS_FRESH:   r_cfg.status_fresh_ms     <= i_cfg.data;
                    default: begin
                        // writes beyond the register list are ignored
                    end
                endcase
            end
            r_s      <= n_s;
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(n_push);
            if (w_frm_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= r_count + CNT_BITS'(n_push) - CNT_BITS'(w_frm_fire);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_queue[r_wr_ptr] <= n_res[0];
        end
        if (n_push == 2'd2) begin
            r_queue[r_wr_ptr + PTR_BITS'(1)] <= n_res[1];
        end
    end

endmodule

@@ rtl/lshs_checker.sv @@
// port-level assertions of the link stop-handshake supervisor and their bind
module lshs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_seq,
    input logic        i_online,
    input logic        i_last
);
    import lshs_pkg::*;

    // no frame word straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("frame valid after reset");

    // a stalled frame word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_kind) && $stable(i_seq)
                                   && $stable(i_online) && $stable(i_last)))
        else $error("stalled frame changed");

    // STOP frames only go out while offline
    a_stop_offline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind == FRAME_STOP)) |-> !i_online)
        else $error("STOP frame while online");

    // heartbeat and status request frames only go out while online
    a_aux_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && ((i_kind == FRAME_HEARTBEAT) || (i_kind == FRAME_STATUS_REQ)))
        |-> i_online)
        else $error("online frame while offline");

endmodule

bind link_stop_handshake_supervisor lshs_checker u_lshs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_frm.valid),
    .i_ready  (o_frm.ready),
    .i_kind   (o_frm.frame_kind),
    .i_seq    (o_frm.frame_seq),
    .i_online (o_frm.online),
    .i_last   (o_frm.last)
);

@@ bench/link_stop_handshake_supervisor_tb.sv @@
// self-checking bench for the link stop-handshake supervisor: event stream in, frames checked
module link_stop_handshake_supervisor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lshs_pkg::*;

    localparam int HALF_NS = 6;              // 12 ns clock
    localparam int LIMIT_NS = 5_000_000;     // far above the length of a clean run
    localparam int DRAIN_CYCLES = 8;         // covers the take of the last word plus the frame queue
    localparam int CHUNK_EVENTS = 230;       // accepted-type events per interval setting
    localparam int NUM_CHUNKS = 6;

    // codes above the stop request are not decoded by the block
    localparam logic [REQ_TYPE_BITS-1:0] REQ_TOP = '1;

    // one event word as the sender sees it
    typedef struct {
        logic [REQ_TYPE_BITS-1:0] kind;
        logic [31:0]              stamp;
        logic [15:0]              seq;
        bit                       stop;
        bit                       ok;
        logic signed [15:0]       left;
        logic signed [15:0]       right;
    } t_event;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lshs_req_if req_ch ();
    lshs_frm_if frm_ch ();
    lshs_cfg_if cfg_ch ();

    link_stop_handshake_supervisor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_frm   (frm_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #HALF_NS i_clk = 1'b1;
        #HALF_NS i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: shadow copy of the handshake state and the intervals
    // ------------------------------------------------------------------
    t_cfg                cfg_now;
    logic [SEQ_BITS-1:0] ctl_seq;        // control sequence, bumped on each restart
    logic [SEQ_BITS-1:0] beat_seq;       // shared by heartbeat and status request frames
    logic [SEQ_BITS-1:0] await_seq;      // sequence the STOP ack has to carry
    logic [31:0]         retry_due;
    logic [31:0]         beat_due;
    logic [31:0]         poll_due;
    logic [31:0]         heard_at;       // last time the controller answered
    logic [31:0]         acked_at;
    logic [31:0]         report_at;      // stamp of the latest status report
    logic [31:0]         losses;
    logic [31:0]         retries;
    bit                  is_acked;
    bit                  is_up;
    bit                  have_report;
    bit                  report_still;   // latest report showed zero drive
    bit                  first_retry;    // first offline tick after reset always sends STOP
    int unsigned         ups;            // times the link came online

    // expected frames, oldest first, and the words still to be sent
    t_result frames_due[$];
    t_event  events_pending[$];
    t_event  cur_event;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned mismatches;
    int unsigned frames_checked;
    int unsigned events_queued;
    int unsigned events_sent;
    int unsigned settings_used;
    logic [31:0] clk_ms;                 // generator's notion of the current time

    function automatic bit is_due(logic [31:0] stamp, logic [31:0] due);
        logic [31:0] diff;
        diff = stamp - due;
        return !diff[31];
    endfunction

    function automatic logic [15:0] seq_low(logic [SEQ_BITS-1:0] s);
        logic [31:0] wide;
        wide = 32'(s);
        return wide[15:0];
    endfunction

    function automatic void predictor_reset();
        cfg_now.stop_retry_ms = STOP_RETRY_RESET;
        cfg_now.heartbeat_ms = HEARTBEAT_RESET;
        cfg_now.status_request_ms = STATUS_REQUEST_RESET;
        cfg_now.response_timeout_ms = RESP_TIMEOUT_RESET;
        cfg_now.status_fresh_ms = STATUS_FRESH_RESET;
        ctl_seq = SEQ_BITS'(1);
        beat_seq = '0;
        await_seq = SEQ_BITS'(1);
        retry_due = '0;
        beat_due = '0;
        poll_due = '0;
        heard_at = '0;
        acked_at = '0;
        report_at = '0;
        losses = '0;
        retries = '0;
        is_acked = 1'b0;
        is_up = 1'b0;
        have_report = 1'b0;
        report_still = 1'b0;
        first_retry = 1'b1;
    endfunction

    // drop the link and wait for a fresh STOP ack under a new sequence
    function automatic void restart_link(logic [31:0] stamp, bit fault);
        is_up = 1'b0;
        is_acked = 1'b0;
        acked_at = '0;
        ctl_seq = ctl_seq + 1'b1;
        await_seq = ctl_seq;
        retry_due = stamp;
        have_report = 1'b0;
        if (fault) begin
            losses = losses + 32'd1;
        end
    endfunction

    function automatic void predict_tick(logic [31:0] stamp);
        logic [1:0]          kinds[2];
        logic [SEQ_BITS-1:0] seqs[2];
        logic [31:0]         age;
        logic [31:0]         quiet;
        t_result             r;
        int                  n;
        int                  k;
        n = 0;
        age = stamp - report_at;
        // a fresh report counts as an answer and may bring the link up
        if (have_report && age <= 32'(cfg_now.status_fresh_ms)) begin
            heard_at = report_at;
            if (is_acked && is_due(report_at, acked_at) && report_still) begin
                if (!is_up) begin
                    ups++;
                end
                is_up = 1'b1;
            end else if (is_up) begin
                restart_link(stamp, 1'b1);
            end
        end else if (is_up) begin
            restart_link(stamp, 1'b1);
        end
        quiet = stamp - heard_at;
        if (is_acked && quiet > 32'(cfg_now.response_timeout_ms)) begin
            restart_link(stamp, 1'b1);
        end
        if (!is_up) begin
            if (first_retry || is_due(stamp, retry_due)) begin
                kinds[n] = FRAME_STOP;
                seqs[n] = await_seq;
                n++;
                retries = retries + 32'd1;
                retry_due = stamp + 32'(cfg_now.stop_retry_ms);
                first_retry = 1'b0;
            end
        end else begin
            if (is_due(stamp, beat_due)) begin
                kinds[n] = FRAME_HEARTBEAT;
                seqs[n] = beat_seq;
                n++;
                beat_seq = beat_seq + 1'b1;
                beat_due = stamp + 32'(cfg_now.heartbeat_ms);
            end
            if (is_due(stamp, poll_due)) begin
                kinds[n] = FRAME_STATUS_REQ;
                seqs[n] = beat_seq;
                n++;
                beat_seq = beat_seq + 1'b1;
                poll_due = stamp + 32'(cfg_now.status_request_ms);
            end
        end
        // flags and counters in every frame reflect the state after the whole tick
        for (k = 0; k < n; k++) begin
            r.frame_kind = kinds[k];
            r.frame_seq = seq_low(seqs[k]);
            r.online = is_up;
            r.link_losses = losses;
            r.stop_count = retries;
            r.last = (k == n - 1);
            frames_due.push_back(r);
        end
    endfunction

    function automatic void predict_event(t_event e);
        case (e.kind)
            REQ_TICK: begin
                predict_tick(e.stamp);
            end
            REQ_ACK: begin
                heard_at = e.stamp;
                if (!is_acked && 32'(e.seq) == 32'(await_seq) && e.stop && e.ok) begin
                    is_acked = 1'b1;
                    acked_at = e.stamp;
                    beat_due = e.stamp;
                    poll_due = e.stamp;
                end
            end
            REQ_STATUS: begin
                have_report = 1'b1;
                report_at = e.stamp;
                report_still = (e.left == 16'sd0) && (e.right == 16'sd0);
            end
            REQ_FAULT: begin
                restart_link(e.stamp, 1'b1);
            end
            REQ_STOP: begin
                restart_link(e.stamp, 1'b0);
            end
            default: begin
                // undecoded code, nothing changes
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("frame %0d %s: got %0h, expected %0h",
                                      frames_checked, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one event word at a time, valid held until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_events
        bit send;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            send = req_ch.valid;
            // word taken at this edge: the block now sees it, so predict it
            if (req_ch.valid && req_ch.ready) begin
                predict_event(cur_event);
                events_sent++;
                send = 1'b0;
            end
            if (!send && events_pending.size() != 0 &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                cur_event = events_pending.pop_front();
                req_ch.req_type <= cur_event.kind;
                req_ch.now_ms <= cur_event.stamp;
                req_ch.ack_seq <= cur_event.seq;
                req_ch.ack_is_stop <= cur_event.stop;
                req_ch.ack_ok <= cur_event.ok;
                req_ch.left_pwm <= cur_event.left;
                req_ch.right_pwm <= cur_event.right;
                send = 1'b1;
            end
            req_ch.valid <= send;
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, every frame word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_frames
        t_result want;
        if (!i_rst_n) begin
            frm_ch.ready <= 1'b0;
        end else begin
            if (frm_ch.valid && frm_ch.ready) begin
                if (frames_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame kind %0d seq %0h",
                                              frm_ch.frame_kind, frm_ch.frame_seq));
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_kind", 32'(frm_ch.frame_kind), 32'(want.frame_kind));
                    check_field("frame_seq", 32'(frm_ch.frame_seq), 32'(want.frame_seq));
                    check_field("online", 32'(frm_ch.online), 32'(want.online));
                    check_field("link_losses", frm_ch.link_losses, want.link_losses);
                    check_field("stop_count", frm_ch.stop_count, want.stop_count);
                    check_field("last", 32'(frm_ch.last), 32'(want.last));
                end
                frames_checked++;
            end
            frm_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // unused fields of a word carry random bits so every input bit toggles
    function automatic t_event rand_event(logic [REQ_TYPE_BITS-1:0] kind, logic [31:0] stamp);
        t_event e;
        e.kind = kind;
        e.stamp = stamp;
        e.seq = 16'($urandom);
        e.stop = 1'($urandom_range(0, 1));
        e.ok = 1'($urandom_range(0, 1));
        e.left = 16'($urandom);
        e.right = 16'($urandom);
        return e;
    endfunction

    function automatic void queue_event(t_event e);
        events_pending.push_back(e);
        if (e.kind <= REQ_STOP) begin
            events_queued++;
        end
    endfunction

    function automatic void queue_tick(logic [31:0] stamp);
        queue_event(rand_event(REQ_TICK, stamp));
    endfunction

    function automatic void queue_ack(logic [31:0] stamp, logic [15:0] seq, bit stop, bit ok);
        t_event e;
        e = rand_event(REQ_ACK, stamp);
        e.seq = seq;
        e.stop = stop;
        e.ok = ok;
        queue_event(e);
    endfunction

    function automatic void queue_status(logic [31:0] stamp, logic signed [15:0] left,
                                         logic signed [15:0] right);
        t_event e;
        e = rand_event(REQ_STATUS, stamp);
        e.left = left;
        e.right = right;
        queue_event(e);
    endfunction

    // status report with drive on at least one side
    function automatic void queue_moving(logic [31:0] stamp);
        logic [15:0] l;
        logic [15:0] r;
        l = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
        r = (l == 16'd0) ? 16'($urandom_range(1, 65535)) : 16'($urandom);
        queue_status(stamp, l, r);
    endfunction

    // every queued word taken, so the predictor is up to date
    task automatic wait_sent();
        while (events_pending.size() != 0 || req_ch.valid) begin
            @(negedge i_clk);
        end
    endtask

    // sender holds off until every predicted frame is back and the block has settled
    task automatic wait_idle();
        wait_sent();
        while (frames_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_STOP_RETRY:     cfg_now.stop_retry_ms = value;
            CFG_HEARTBEAT:      cfg_now.heartbeat_ms = value;
            CFG_STATUS_REQUEST: cfg_now.status_request_ms = value;
            CFG_RESP_TIMEOUT:   cfg_now.response_timeout_ms = value;
            CFG_STATUS_FRESH:   cfg_now.status_fresh_ms = value;
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(logic [15:0] retry, logic [15:0] beat, logic [15:0] poll,
                                  logic [15:0] quiet, logic [15:0] fresh);
        write_reg(CFG_STOP_RETRY, retry);
        write_reg(CFG_HEARTBEAT, beat);
        write_reg(CFG_STATUS_REQUEST, poll);
        write_reg(CFG_RESP_TIMEOUT, quiet);
        write_reg(CFG_STATUS_FRESH, fresh);
        settings_used++;
        @(negedge i_clk);
    endtask

    // one handshake attempt: STOP out, ack back, zero-drive reports, then time online
    task automatic run_session(int unsigned gap_max);
        logic [15:0] want_seq;
        int unsigned flaw;
        int unsigned laps;
        int unsigned roll;
        int unsigned k;
        clk_ms += $urandom_range(0, gap_max);
        queue_tick(clk_ms);
        wait_sent();
        want_seq = seq_low(await_seq);
        flaw = $urandom_range(0, 15);
        clk_ms += $urandom_range(0, gap_max / 4);
        case (flaw)
            0: queue_ack(clk_ms, want_seq + 16'd1 + 16'($urandom_range(0, 3)), 1'b1, 1'b1);
            1: queue_ack(clk_ms, want_seq, 1'b0, 1'b1);
            2: queue_ack(clk_ms, want_seq, 1'b1, 1'b0);
            default: queue_ack(clk_ms, want_seq, 1'b1, 1'b1);
        endcase
        // first report: normally zero drive and not older than the ack
        if (flaw == 3) begin
            queue_status(clk_ms - 32'd1 - 32'($urandom_range(0, 5)), 16'sd0, 16'sd0);
        end else if (flaw == 4) begin
            queue_moving(clk_ms);
        end else begin
            clk_ms += $urandom_range(0, gap_max / 4);
            queue_status(clk_ms, 16'sd0, 16'sd0);
        end
        clk_ms += $urandom_range(0, gap_max / 4);
        queue_tick(clk_ms);
        // keep the link fed, with the odd silence, moving report or fault
        laps = $urandom_range(1, 10);
        for (k = 0; k < laps; k++) begin
            clk_ms += $urandom_range(0, gap_max / 2);
            roll = $urandom_range(0, 31);
            if (roll == 1) begin
                queue_moving(clk_ms);
            end else if (roll == 2) begin
                queue_event(rand_event($urandom_range(0, 1) ? REQ_FAULT : REQ_STOP, clk_ms));
            end else if (roll == 3) begin
                queue_event(rand_event(REQ_ACK, clk_ms));
            end else if (roll != 0) begin
                queue_status(clk_ms, 16'sd0, 16'sd0);
            end
            clk_ms += $urandom_range(0, gap_max / 2);
            queue_tick(clk_ms);
        end
        if ($urandom_range(0, 2) == 0) begin
            queue_event(rand_event(REQ_STOP, clk_ms));
        end
    endtask

    // short burst of arbitrary words, a few with wild stamps or undecoded codes
    task automatic run_noise(int unsigned gap_max);
        t_event      e;
        logic [31:0] stamp;
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            clk_ms += $urandom_range(0, gap_max);
            stamp = ($urandom_range(0, 15) == 0) ? 32'($urandom) : clk_ms;
            if ($urandom_range(0, 9) == 0) begin
                e = rand_event(REQ_TYPE_BITS'($urandom_range(REQ_STOP + 1, REQ_TOP)), stamp);
            end else begin
                e = rand_event(REQ_TYPE_BITS'($urandom_range(REQ_TICK, REQ_STOP)), stamp);
            end
            queue_event(e);
        end
    endtask

    // ------------------------------------------------------------------
    // known values on every input from time zero
    // ------------------------------------------------------------------
    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.now_ms = '0;
        req_ch.ack_seq = '0;
        req_ch.ack_is_stop = 1'b0;
        req_ch.ack_ok = 1'b0;
        req_ch.left_pwm = '0;
        req_ch.right_pwm = '0;
        frm_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_STOP_RETRY;
        cfg_ch.data = '0;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin
        #LIMIT_NS;
        $display("timeout: %0d words waiting, %0d frames outstanding",
                 events_pending.size(), frames_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_flow
        logic [15:0] s;
        int          code;
        int          ch;
        int unsigned span;
        int unsigned chunk_start;
        predictor_reset();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        mismatches = 0;
        frames_checked = 0;
        events_queued = 0;
        events_sent = 0;
        settings_used = 0;
        ups = 0;
        clk_ms = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part runs on the default intervals, written explicitly
        apply_settings(STOP_RETRY_RESET, HEARTBEAT_RESET, STATUS_REQUEST_RESET,
                       RESP_TIMEOUT_RESET, STATUS_FRESH_RESET);
        queue_tick(32'd1000);                  // first offline tick sends STOP
        queue_tick(32'd1100);                  // retry not yet due
        queue_tick(32'd1250);                  // retry due
        for (code = REQ_STOP + 1; code <= REQ_TOP; code++) begin
            queue_event(rand_event(REQ_TYPE_BITS'(code), 32'd1255));   // undecoded codes
        end
        wait_sent();
        s = seq_low(await_seq);
        queue_ack(32'd1260, s + 16'd1, 1'b1, 1'b1);    // wrong sequence
        queue_ack(32'd1270, s, 1'b0, 1'b1);            // not a STOP ack
        queue_ack(32'd1280, s, 1'b1, 1'b0);            // result not OK
        queue_ack(32'd1300, s, 1'b1, 1'b1);            // matching STOP ack
        queue_status(32'd1290, 16'sd0, 16'sd0);        // report older than the ack
        queue_tick(32'd1305);
        queue_status(32'd1310, 16'sh8000, 16'sh7FFF);  // drive still applied
        queue_tick(32'd1320);
        queue_status(32'd1330, 16'sd0, 16'sd0);
        queue_tick(32'd1340);                  // online: heartbeat and status request
        queue_status(32'd1600, 16'sd0, 16'sd0);
        queue_tick(32'd1850);
        queue_tick(32'd2200);                  // report gone stale, link lost
        wait_sent();
        s = seq_low(await_seq);
        queue_ack(32'd2300, s, 1'b1, 1'b1);
        queue_tick(32'd3600);                  // silence past the response timeout
        queue_event(rand_event(REQ_FAULT, 32'd3700));
        queue_tick(32'd3700);
        queue_event(rand_event(REQ_STOP, 32'd3800));
        queue_tick(32'd3800);
        queue_tick(32'hFFFF_FFFF);             // time wraps between these two
        queue_tick(32'h0000_0010);
        wait_idle();

        // random part: one interval setting per chunk, idle pattern per pair of chunks
        for (ch = 0; ch < NUM_CHUNKS; ch++) begin
            case (ch / 2)
                0: begin
                    src_idle_pct = 8;
                    snk_idle_pct = 71;
                end
                1: begin
                    src_idle_pct = 71;
                    snk_idle_pct = 8;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            case (ch)
                0: apply_settings(16'($urandom_range(100, 1500)),
                                  16'($urandom_range(100, 1500)),
                                  16'($urandom_range(100, 1500)),
                                  16'($urandom_range(100, 1500)),
                                  16'($urandom_range(100, 1500)));
                1: apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_settings(16'($urandom_range(1, 2000)),
                                  16'($urandom_range(1, 2000)),
                                  16'($urandom_range(1, 2000)),
                                  16'($urandom_range(1, 2000)),
                                  16'($urandom_range(0, 2000)));
                4: apply_settings(16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(0, 65535)));
                default: apply_settings(STOP_RETRY_RESET, HEARTBEAT_RESET,
                                        STATUS_REQUEST_RESET, RESP_TIMEOUT_RESET,
                                        STATUS_FRESH_RESET);
            endcase
            // time steps sized so a fed link mostly stays fresh
            span = 2 * int'(cfg_now.status_fresh_ms) + 2;
            if (span > 60000) begin
                span = 60000;
            end
            clk_ms = $urandom;
            chunk_start = events_queued;
            while (events_queued - chunk_start < CHUNK_EVENTS) begin
                if ($urandom_range(0, 9) < 7) begin
                    run_session(span);
                end else begin
                    run_noise(span);
                end
                if ($urandom_range(0, 39) == 0) begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        if (frames_due.size() != 0) begin
            report_mismatch($sformatf("%0d predicted frames never came", frames_due.size()));
        end
        $display("run covered %0d event words over %0d interval settings, %0d frames checked",
                 events_sent, settings_used, frames_checked);
        $display("link came online %0d times, %0d link losses and %0d STOP frames seen",
                 ups, losses, retries);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
